### rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types for the first-fit region allocator: the request and response
// payloads and the command bundle that drives the occupancy memory.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Request kinds.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // One input item.
    typedef struct packed {
        logic       kind;
        logic [7:0] owner_id;
        logic [6:0] instr_count;
        logic       region_valid;
        logic [5:0] region_start;
        logic [5:0] region_end;
    } t_req;

    // One result item.
    typedef struct packed {
        logic       ok;
        logic [5:0] base_word;
        logic [5:0] last_word;
    } t_rsp;

    // Control strobes from the sequencer to the word memories.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic wr_use;
    } t_mem_cmd;

endpackage

### rtl/ffra_mem.sv
// ----------------------------------------------------------------------------
// ffra_mem
// Word state storage: a one-bit occupancy memory with one synchronous read
// port and one write port, and an owner memory that is written alongside it.
// ----------------------------------------------------------------------------
module ffra_mem #(
    parameter int MEM_WORDS = 64,
    parameter int AW        = 6
) (
    input  logic               i_clk,
    input  ffra_pkg::t_mem_cmd i_cmd,
    input  logic [AW-1:0]      i_waddr,
    input  logic [AW-1:0]      i_raddr,
    input  logic [7:0]         i_owner,
    output logic               o_use
);
    import ffra_pkg::*;

    logic       r_use_mem   [MEM_WORDS];
    logic [7:0] r_owner_mem [MEM_WORDS];
    logic       r_rd_use;

    // Write port: occupancy always, owner only when a word is claimed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_use_mem[i_waddr] <= i_cmd.wr_use;
            if (i_cmd.wr_use) begin
                r_owner_mem[i_waddr] <= i_owner;
            end
        end
    end

    // Registered read port, enabled by rd_en.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_use <= r_use_mem[i_raddr];
        end
    end

    assign o_use = r_rd_use;

endmodule

### rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer for the allocator: clears the occupancy memory after reset,
// scans it one word a cycle for the lowest free run, marks the found run,
// clears released ranges and presents one response per request.
// ----------------------------------------------------------------------------
module ffra_ctrl #(
    parameter int MEM_WORDS    = 64,
    parameter int HEADER_WORDS = 4,
    parameter int VAR_WORDS    = 3,
    parameter int AW           = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  ffra_pkg::t_req     i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_take,
    output ffra_pkg::t_rsp     o_rsp,
    output ffra_pkg::t_mem_cmd o_cmd,
    output logic [AW-1:0]      o_waddr,
    output logic [AW-1:0]      o_raddr,
    output logic [7:0]         o_owner,
    input  logic               i_use
);
    import ffra_pkg::*;

    localparam int CW = $clog2(MEM_WORDS + 1);
    localparam int NW = ((CW > 8) ? CW : 8) + 1;
    localparam int WW = (CW > 6) ? CW : 6;

    localparam logic [CW-1:0] LAST_ADDR = CW'(MEM_WORDS - 1);
    localparam logic [CW-1:0] END_ADDR  = CW'(MEM_WORDS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]    r_state,     n_state;
    logic [CW-1:0] r_addr,      n_addr;
    logic [CW-1:0] r_end,       n_end;
    logic          r_rd_vld,    n_rd_vld;
    logic [CW-1:0] r_rd_addr,   n_rd_addr;
    logic [NW-1:0] r_run_len,   n_run_len;
    logic [CW-1:0] r_run_start, n_run_start;
    logic [NW-1:0] r_need,      n_need;
    logic [7:0]    r_owner,     n_owner;
    logic          r_ok,        n_ok;
    logic [CW-1:0] r_base,      n_base;
    logic [CW-1:0] r_last,      n_last;

    logic [NW-1:0] w_need;
    logic [NW-1:0] w_rel_start;
    logic [NW-1:0] w_rel_end;
    logic [WW-1:0] w_base_ext;
    logic [WW-1:0] w_last_ext;
    logic          w_rd_en;

    // Request decode helpers.
    assign w_need = NW'(HEADER_WORDS) + NW'(VAR_WORDS) + NW'(i_req.instr_count);
    assign w_rel_start = NW'(i_req.region_start);
    assign w_rel_end   = (NW'(i_req.region_end) > NW'(LAST_ADDR)) ?
                         NW'(LAST_ADDR) : NW'(i_req.region_end);

    // Reads are issued while the scan pointer is inside the memory.
    assign w_rd_en = (r_state == S_SCAN) && (r_addr < END_ADDR);

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_end       = r_end;
        n_rd_vld    = w_rd_en;
        n_rd_addr   = r_addr;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_need      = r_need;
        n_owner     = r_owner;
        n_ok        = r_ok;
        n_base      = r_base;
        n_last      = r_last;

        unique case (r_state)
            S_INIT: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_ok   = 1'b1;
                    n_base = '0;
                    n_last = '0;
                    if (i_req.kind == KIND_ALLOC) begin
                        if ((w_need == '0) || (w_need > NW'(MEM_WORDS))) begin
                            n_ok    = 1'b0;
                            n_state = S_RESP;
                        end else begin
                            n_need      = w_need;
                            n_owner     = i_req.owner_id;
                            n_addr      = '0;
                            n_run_len   = '0;
                            n_run_start = '0;
                            n_state     = S_SCAN;
                        end
                    end else if (i_req.region_valid && (w_rel_start <= w_rel_end)) begin
                        n_addr  = CW'(w_rel_start);
                        n_end   = CW'(w_rel_end);
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (w_rd_en) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rd_vld) begin
                    if (i_use) begin
                        n_run_len   = '0;
                        n_run_start = r_rd_addr + 1'b1;
                    end else begin
                        n_run_len = r_run_len + 1'b1;
                    end
                    if (!i_use && ((r_run_len + 1'b1) == r_need)) begin
                        // Lowest free run of the needed length found.
                        n_ok    = 1'b1;
                        n_base  = r_run_start;
                        n_last  = r_rd_addr;
                        n_addr  = r_run_start;
                        n_end   = r_rd_addr;
                        n_state = S_MARK;
                    end else if (r_rd_addr == LAST_ADDR) begin
                        n_ok    = 1'b0;
                        n_state = S_RESP;
                    end
                end
            end
            S_MARK, S_CLEAR: begin
                if (r_addr == r_end) begin
                    n_state = S_RESP;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RESP: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_addr  = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_rd_addr   <= n_rd_addr;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_need      <= n_need;
        r_owner     <= n_owner;
        r_ok        <= n_ok;
        r_base      <= n_base;
        r_last      <= n_last;
    end

    // Memory access.
    always_comb begin
        o_cmd.wr_en  = (r_state == S_INIT) || (r_state == S_MARK) || (r_state == S_CLEAR);
        o_cmd.rd_en  = w_rd_en;
        o_cmd.wr_use = (r_state == S_MARK);
    end
    assign o_waddr = r_addr[AW-1:0];
    assign o_raddr = r_addr[AW-1:0];
    assign o_owner = r_owner;

    // Handshake and response; bounds are reported modulo 64.
    assign o_req_ready     = (r_state == S_IDLE);
    assign o_rsp_valid     = (r_state == S_RESP);
    assign w_base_ext      = WW'(r_base);
    assign w_last_ext      = WW'(r_last);
    assign o_rsp.ok        = r_ok;
    assign o_rsp.base_word = w_base_ext[5:0];
    assign o_rsp.last_word = w_last_ext[5:0];

endmodule

### rtl/first_fit_region_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit contiguous region allocator over an occupancy map of words.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (i_in_valid, o_in_ready, i_in_data) carries allocate
//   and release requests; the response channel (o_out_valid, i_out_ready,
//   o_out_data) returns exactly one response per request, in order.
//   One request is processed at a time. The occupancy memory has a single
//   read port, so an allocation scans one word per cycle, then marks the
//   words of the found region one at a time. A release clears the freed
//   words one at a time; a rejected request goes straight to the response.
//   Transfers on the request side are ready again in the cycle after the
//   response moves into the output register.
//   After reset the block walks the whole memory marking every word free,
//   one word per cycle; o_in_ready stays low during that pass.
//   When the receiver stalls, the finished response waits in the output
//   register and the block may accept and work on the next request; that
//   request's response is held inside until the register empties.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top #(
    parameter int MEM_WORDS    = 64,
    parameter int HEADER_WORDS = 4,
    parameter int VAR_WORDS    = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffra_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ffra_pkg::t_rsp o_out_data
);
    import ffra_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    t_mem_cmd      w_cmd;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_owner;
    logic          w_use;
    logic          w_rsp_valid;
    logic          w_rsp_take;
    t_rsp          w_rsp;

    logic          r_out_valid;
    t_rsp          r_out_data;

    ffra_ctrl #(
        .MEM_WORDS    (MEM_WORDS),
        .HEADER_WORDS (HEADER_WORDS),
        .VAR_WORDS    (VAR_WORDS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_data),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_take  (w_rsp_take),
        .o_rsp       (w_rsp),
        .o_cmd       (w_cmd),
        .o_waddr     (w_waddr),
        .o_raddr     (w_raddr),
        .o_owner     (w_owner),
        .i_use       (w_use)
    );

    ffra_mem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .i_owner (w_owner),
        .o_use   (w_use)
    );

    // Output register: loads whenever it is empty or being drained.
    assign w_rsp_take = w_rsp_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_take) begin
            r_out_data <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ffra_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ffra_pkg::t_rsp o_out_data
);
    import ffra_pkg::*;

    // A stalled response keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("response changed while stalled");

    // The clearing pass after reset keeps the request side closed.
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request accepted right after reset");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request accepted back to back");

    // A failed allocation reports zero bounds.
    a_fail_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |->
        ((o_out_data.base_word == 6'd0) && (o_out_data.last_word == 6'd0)))
        else $error("failed response with nonzero bounds");

endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
